### design/olsr_pkg.sv
// Shared constants and types for the ordered list search and remove block.
// Used by ordered_list_search_remove_top, olsr_list_sb_pkg and tb_top; depends on nothing.
`default_nettype none

package olsr_pkg;

  localparam int DEPTH         = 16;
  localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int DATA_W        = 32;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

### design/olsr_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; holds the list entries of the top level.
`default_nettype none

module olsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/ordered_list_search_remove_top.sv
// Top level of the ordered list search and remove block: sequencer and result registers.
// Depends on olsr_pkg and olsr_ram.
//
// Usage: an operation beat is taken at a rising edge where start is high and busy is
// low, carrying mode and value. Exactly one result beat follows: done is high for one
// cycle with hit, status, entry_count and is_empty, and the receiver must take it then,
// as it cannot stall the block.
// An append, a no-operation, or a search or removal on an empty list gives its
// result in the cycle after the start beat. A search walks the stored entries through
// the single RAM read port, one entry a cycle, with one equality compare shared by all
// entries, and ends at the first match or at the last entry. A removal then moves every
// later entry down one place through the same port, one entry a cycle, then lowers the
// count. busy stays high throughout, so one operation is in flight at a time.
// Reset clears the entry count; the RAM contents need no clearing, since only entries
// below the count are ever used.
`default_nettype none

module ordered_list_search_remove_top
  import olsr_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic        [MODE_W-1:0]        mode,
  input  wire logic signed [DATA_W-1:0]        value,
  output logic                                 done,
  output logic                                 hit,
  output logic             [STATUS_W-1:0]      status,
  output logic             [ENTRY_COUNT_W-1:0] entry_count,
  output logic                                 is_empty
);

  state_t state, state_next;

  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    rd_idx, rd_idx_next;
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic                cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0]    wr_idx, wr_idx_next;
  logic                wr_pend, wr_pend_next;
  logic [MODE_W-1:0]   op_mode, op_mode_next;
  logic [DATA_W-1:0]   key, key_next;

  logic                done_next;
  logic                hit_next;
  logic [STATUS_W-1:0] status_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                match;
  logic                last;
  logic                more;
  logic                walk_op;

  olsr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The compare looks at the entry read in the previous cycle.
  assign match   = cmp_vld && (ram_rdata == key);
  assign last    = cmp_vld && (CNT_W'(cmp_idx) == (count - CNT_W'(1)));
  assign more    = rd_idx < count;
  assign walk_op = (mode == MODE_SEARCH) || (mode == MODE_REMOVE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && walk_op && (count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match && (op_mode == MODE_REMOVE)) begin
          state_next = ST_SHIFT;
        end else if (match || last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (!more && !wr_pend) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next   = count;
    rd_idx_next  = rd_idx;
    cmp_idx_next = cmp_idx;
    cmp_vld_next = 1'b0;
    wr_idx_next  = wr_idx;
    wr_pend_next = 1'b0;
    op_mode_next = op_mode;
    key_next     = key;
    done_next    = 1'b0;
    hit_next     = 1'b0;
    status_next  = STAT_OK;
    ram_we       = 1'b0;
    ram_waddr    = wr_idx;
    ram_wdata    = ram_rdata;
    ram_raddr    = rd_idx[IDX_W-1:0];

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_mode_next = mode;
          key_next     = value;
          rd_idx_next  = '0;
          case (mode)
            MODE_APPEND: begin
              done_next = 1'b1;
              if (count >= CNT_W'(DEPTH)) begin
                status_next = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[IDX_W-1:0];
                ram_wdata  = value;
                count_next = count + CNT_W'(1);
              end
            end
            MODE_SEARCH, MODE_REMOVE: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = STAT_EMPTY;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end

      ST_SCAN: begin
        if (match) begin
          if (op_mode == MODE_REMOVE) begin
            rd_idx_next = CNT_W'(cmp_idx) + CNT_W'(1);
          end else begin
            done_next = 1'b1;
            hit_next  = 1'b1;
          end
        end else if (last) begin
          done_next   = 1'b1;
          status_next = STAT_MISSING;
        end else if (more) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = rd_idx[IDX_W-1:0];
          rd_idx_next  = rd_idx + CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        // Entry read last cycle lands one place lower.
        if (wr_pend) begin
          ram_we = 1'b1;
        end
        if (more) begin
          wr_pend_next = 1'b1;
          wr_idx_next  = IDX_W'(rd_idx - CNT_W'(1));
          rd_idx_next  = rd_idx + CNT_W'(1);
        end else if (!wr_pend) begin
          count_next = count - CNT_W'(1);
          done_next  = 1'b1;
          hit_next   = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
      wr_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_vld <= cmp_vld_next;
      wr_pend <= wr_pend_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    cmp_idx <= cmp_idx_next;
    wr_idx  <= wr_idx_next;
    op_mode <= op_mode_next;
    key     <= key_next;
    hit     <= hit_next;
    status  <= status_next;
  end

  assign busy        = (state != ST_IDLE);
  assign entry_count = ENTRY_COUNT_W'(count);
  assign is_empty    = (count == '0);

endmodule

`default_nettype wire

### verif/olsr_list_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the ordered list search and remove block: a shadow copy of the list
// that predicts every result, and a queue of results still to arrive. Depends on olsr_pkg.
package olsr_list_sb_pkg;
  import olsr_pkg::*;

  // The block treats the fourth mode code as a no-operation.
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int MAX_PRINTED = 60;

  typedef struct packed {
    logic                     hit;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     is_empty;
  } list_result_t;

  class olsr_scoreboard;
    logic signed [DATA_W-1:0] shadow_list[$];
    list_result_t             awaited_results[$];
    int                       errors;
    int                       results_seen;
    int                       mode_seen[4];
    int                       status_seen[4];
    int                       hits;
    int                       peak_count;

    function new();
      errors       = 0;
      results_seen = 0;
      hits         = 0;
      peak_count   = 0;
      foreach (mode_seen[i]) mode_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Applies one accepted operation beat to the shadow list and queues its result.
    function void note_op(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v);
      list_result_t r;
      int           pos;
      r        = '0;
      r.status = STAT_OK;
      pos      = -1;
      case (m)
        MODE_APPEND: begin
          if (shadow_list.size() >= DEPTH) r.status = STAT_FULL;
          else shadow_list.push_back(v);
        end
        MODE_SEARCH, MODE_REMOVE: begin
          if (shadow_list.size() == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            // Only the oldest match counts, so duplicates further on are left alone.
            foreach (shadow_list[i])
              if (pos < 0 && shadow_list[i] == v) pos = i;
            if (pos < 0) begin
              r.status = STAT_MISSING;
            end else begin
              r.hit = 1'b1;
              if (m == MODE_REMOVE) shadow_list.delete(pos);
            end
          end
        end
        default: ;
      endcase
      r.entry_count = ENTRY_COUNT_W'(shadow_list.size());
      r.is_empty    = (shadow_list.size() == 0);
      awaited_results.push_back(r);
      mode_seen[m]++;
      status_seen[r.status]++;
      if (r.hit) hits++;
      if (shadow_list.size() > peak_count) peak_count = shadow_list.size();
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    function int stored_count();
      return shadow_list.size();
    endfunction

    function logic signed [DATA_W-1:0] any_stored();
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("olsr mismatch %0d: %s", errors, what);
    endtask

    task check_result(logic h, logic [STATUS_W-1:0] s, logic [ENTRY_COUNT_W-1:0] c,
                      logic e);
      list_result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with no operation outstanding",
                                  results_seen));
        return;
      end
      want = awaited_results.pop_front();
      if (h !== want.hit)
        report_mismatch($sformatf("beat %0d: hit %b, expected %b", results_seen, h, want.hit));
      if (s !== want.status)
        report_mismatch($sformatf("beat %0d: status %0d, expected %0d",
                                  results_seen, s, want.status));
      if (c !== want.entry_count)
        report_mismatch($sformatf("beat %0d: entry_count %0d, expected %0d",
                                  results_seen, c, want.entry_count));
      if (e !== want.is_empty)
        report_mismatch($sformatf("beat %0d: is_empty %b, expected %b",
                                  results_seen, e, want.is_empty));
    endtask

    task close_out();
      if (awaited_results.size() != 0)
        report_mismatch($sformatf("%0d result beats never arrived", awaited_results.size()));
    endtask

    function void print_summary();
      $display("Covered %0d appends, %0d searches, %0d removals and %0d no-ops; %0d hits.",
               mode_seen[MODE_APPEND], mode_seen[MODE_SEARCH], mode_seen[MODE_REMOVE],
               mode_seen[MODE_NOP], hits);
      $display({"Outcomes: %0d ok, %0d on an empty list, %0d dropped when full, ",
                "%0d misses; list peaked at %0d entries."},
               status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
               status_seen[STAT_MISSING], peak_count);
    endfunction
  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for ordered_list_search_remove_top: clock, reset, operation
// driver and result monitor. Depends on olsr_pkg and olsr_list_sb_pkg.
module tb_top;
  import olsr_pkg::*;
  import olsr_list_sb_pkg::*;

  localparam int RANDOM_OPS   = 1150;
  localparam int QUIET_TAIL   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;
  logic                     done;
  logic                     hit;
  logic [STATUS_W-1:0]      status;
  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic                     is_empty;
  int                       stall_cycles;
  olsr_scoreboard           sb;

  ordered_list_search_remove_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .value       (value),
    .done        (done),
    .hit         (hit),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off, so every done beat is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(hit, status, entry_count, is_empty);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Holds start high until the beat is taken and busy has dropped; start is left high for a following beat.
  task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
    start <= 1'b1;
    mode  <= m;
    value <= v;
    do @(posedge clk); while (busy);
    sb.note_op(m, v);
  endtask

  // Junk on mode and value while start is low must be ignored.
  task automatic idle_burst(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      mode  <= MODE_W'($urandom_range(0, 3));
      value <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pool_value(input int idx);
    case (idx)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      5:       return 32'sd5;
      6:       return 32'sh5555_5555;
      default: return 32'shAAAA_AAAA;
    endcase
  endfunction

  // Lookups mostly aim at stored values so that removals reach deep into the list.
  function automatic logic signed [DATA_W-1:0] pick_value(input bit lookup);
    int r;
    r = $urandom_range(0, 99);
    if (lookup && sb.stored_count() != 0 && r < 60) return sb.any_stored();
    if (r < 75) return pool_value($urandom_range(0, 7));
    return $urandom;
  endfunction

  // lean 0 fills the list, 1 drains it, 2 fills it more gently.
  function automatic logic [MODE_W-1:0] pick_mode(input int lean);
    int r;
    int appends;
    r       = $urandom_range(0, 99);
    appends = (lean == 0) ? 65 : (lean == 1) ? 22 : 45;
    if (r < 3) return MODE_NOP;
    if (r < 3 + appends) return MODE_APPEND;
    if (r < 3 + appends + (97 - appends) / 2) return MODE_SEARCH;
    return MODE_REMOVE;
  endfunction

  initial begin
    logic signed [DATA_W-1:0] fill_vals[12];
    logic [MODE_W-1:0]        m;
    int                       lean;
    bit                       gappy;
    sb    = new();
    rst   = 1'b1;
    start = 1'b0;
    mode  = '0;
    value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty list cases, then the extremes of the value field with a duplicate.
    send_op(MODE_SEARCH, 32'sd0);
    send_op(MODE_REMOVE, -32'sd1);
    send_op(MODE_NOP, 32'sd7);
    send_op(MODE_APPEND, 32'sh8000_0000);
    send_op(MODE_APPEND, 32'sh7FFF_FFFF);
    send_op(MODE_APPEND, 32'sd0);
    send_op(MODE_APPEND, -32'sd1);
    send_op(MODE_APPEND, -32'sd1);
    send_op(MODE_SEARCH, 32'sh7FFF_FFFF);
    send_op(MODE_SEARCH, 32'sd5);
    send_op(MODE_REMOVE, -32'sd1);
    send_op(MODE_SEARCH, -32'sd1);
    // Fill to the brim, try one append too many, then remove at both ends.
    foreach (fill_vals[i]) begin
      fill_vals[i] = $urandom;
      send_op(MODE_APPEND, fill_vals[i]);
    end
    send_op(MODE_APPEND, 32'sd1);
    send_op(MODE_REMOVE, 32'sh8000_0000);
    send_op(MODE_REMOVE, fill_vals[11]);
    send_op(MODE_NOP, -32'sd1);
    wait_for_results();

    lean  = 2;
    gappy = 1'b0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 48 == 0) begin
        lean  = $urandom_range(0, 2);
        gappy = $urandom_range(0, 1);
      end
      if (n % 300 == 299) wait_for_results();
      m = pick_mode(lean);
      send_op(m, pick_value(m == MODE_SEARCH || m == MODE_REMOVE));
      if (gappy && n < RANDOM_OPS - QUIET_TAIL && $urandom_range(0, 2) == 0)
        idle_burst($urandom_range(1, 16));
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    sb.print_summary();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/olsr_pkg.sv
design/olsr_ram.sv
design/ordered_list_search_remove_top.sv
verif/olsr_list_sb_pkg.sv
verif/tb_top.sv
